@@ sv/rotated_region_bounds_core_macros.svh @@
// assertion macros for the rotated region bounds core
// expects clk and rst in the scope of every use
`ifndef ROTATED_REGION_BOUNDS_CORE_MACROS_SVH
`define ROTATED_REGION_BOUNDS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define RRB_ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RRB_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/rrb_pkg.sv @@
// shared types and constants of the rotated region bounds core
// no dependencies
package rrb_pkg;

  // cordic datapath widths
  localparam int XY_W = 20;
  localparam int Z_W = 32;
  localparam int SC_W = 18;
  localparam int Q_ONE = 65536;
  localparam int CORDIC_GAIN = 39797;
  localparam int ATAN_LEN = 24;

  // atan(2^-i) in degrees, q8.24
  localparam logic signed [Z_W-1:0] ATAN_Q24 [ATAN_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509720,
    32'sd3754917, 32'sd1877466, 32'sd938734, 32'sd469367,
    32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
    32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115
  };

  // input word
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [15:0] angle_about_x;
    logic signed [15:0] angle_about_y;
    logic signed [15:0] angle_about_z;
  } item_t;

  // output word
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } result_t;

  // one cordic lane as it moves along the cell row
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic neg;
  } lane_t;

endpackage

@@ sv/rrb_angle_prep.sv @@
// angle reduction into the cordic range and lane seeding
// depends on rrb_pkg
module rrb_angle_prep #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic signed [15:0] angle,
  output rrb_pkg::lane_t     lane
);
  import rrb_pkg::*;

  // number of fold steps so that turn << k covers the 16-bit range
  function automatic int fold_steps(input int turn);
    int k;
    k = 0;
    for (int i = 0; i < 16; i++) begin
      if ((turn << k) < 32768) k = k + 1;
    end
    return k;
  endfunction

  localparam int RW = 24;
  localparam int TURN = 360 << ANGLE_FRAC_BITS;
  localparam int HALF = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int K = fold_steps(TURN);
  localparam int BIG = TURN << K;

  logic signed [RW-1:0] a;
  logic neg;

  // modulo a full turn, then fold into +-90 degrees
  always_comb begin
    a = {{(RW-16){angle[15]}}, angle};
    if (a < 0) a = a + RW'(BIG);
    for (int k = K; k >= 0; k--) begin
      if (a >= RW'(TURN << k)) a = a - RW'(TURN << k);
    end
    if (a > RW'(HALF)) a = a - RW'(TURN);
    neg = 1'b0;
    if (a > RW'(QUARTER)) begin
      a = a - RW'(HALF);
      neg = 1'b1;
    end else if (a < RW'(-QUARTER)) begin
      a = a + RW'(HALF);
      neg = 1'b1;
    end
    lane.x = XY_W'(CORDIC_GAIN);
    lane.y = '0;
    lane.z = Z_W'(a) <<< (24 - ANGLE_FRAC_BITS);
    lane.neg = neg;
  end

endmodule

@@ sv/rrb_cordic_cell.sv @@
// one cordic rotation cell, registered, passes its lane to the next cell
// depends on rrb_pkg
module rrb_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  rrb_pkg::lane_t d,
  output rrb_pkg::lane_t q
);
  import rrb_pkg::*;

  lane_t nxt;
  logic signed [XY_W-1:0] shx, shy;

  // micro-rotation towards zero residual angle
  always_comb begin
    shx = d.x >>> STAGE;
    shy = d.y >>> STAGE;
    nxt = d;
    if (!d.z[Z_W-1]) begin
      nxt.x = d.x - shy;
      nxt.y = d.y + shx;
      nxt.z = d.z - ATAN_Q24[STAGE];
    end else begin
      nxt.x = d.x + shy;
      nxt.y = d.y - shx;
      nxt.z = d.z + ATAN_Q24[STAGE];
    end
  end

  // hand on to the neighbour
  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

@@ sv/rotated_region_bounds_core.sv @@
// rotated region bounds core: bounding box of a rectangle under an xyz rotation
// throughput: one word per cycle while the skid word is empty, set by the cordic cell row and multiplier stages
// a skid word at the output keeps the input open while one result waits
// reset (rst, synchronous) clears the valid pipeline and the output and skid valid flags only
// depends on rrb_pkg, rrb_angle_prep, rrb_cordic_cell and the macros header
`include "rotated_region_bounds_core_macros.svh"
module rotated_region_bounds_core #(
  parameter int COORD_BITS = 32,
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  rrb_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  output rrb_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);
  import rrb_pkg::*;

  localparam int N = CORDIC_STAGES;
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int MW = 20;
  localparam int PW = MW + DW;
  localparam int TW = CW + 23;
  localparam int GD = N + 4;
  localparam int LAST = N + 6;
  localparam int SW = 2 * SC_W + 20;

  localparam logic signed [TW-1:0] HI = (TW'(1) << (CW - 1)) - TW'(1);
  localparam logic signed [TW-1:0] LO = -(TW'(1) << (CW - 1));

  typedef struct packed {
    logic signed [CW-1:0] cx, cy;
    logic signed [DW-1:0] dax, day, dbx, dby;
  } geo_t;

  // clamp to +-1.0 and apply the half-turn sign
  function automatic logic signed [SC_W-1:0] sc_fix(input logic signed [XY_W-1:0] v,
                                                    input logic neg);
    logic signed [XY_W-1:0] c;
    c = v;
    if (v > XY_W'(Q_ONE)) c = XY_W'(Q_ONE);
    else if (v < XY_W'(-Q_ONE)) c = XY_W'(-Q_ONE);
    if (neg) c = -c;
    return c[SC_W-1:0];
  endfunction

  // centre plus rotated offset, truncated toward zero, saturated
  function automatic logic signed [31:0] rot(input logic signed [CW-1:0] c,
                                             input logic signed [PW-1:0] p0,
                                             input logic signed [PW-1:0] p1);
    logic signed [TW-1:0] t, u, r;
    t = (TW'(c) <<< 16) + TW'(p0) + TW'(p1);
    u = t + (t[TW-1] ? TW'(65535) : TW'(0));
    r = u >>> 16;
    if (r > HI) r = HI;
    else if (r < LO) r = LO;
    return r[31:0];
  endfunction

  logic adv;
  logic [LAST:0] vld;
  rrb_pkg::lane_t la [0:N];
  rrb_pkg::lane_t lb [0:N];
  rrb_pkg::lane_t lc [0:N];
  rrb_pkg::lane_t pa, pb, pc;
  geo_t geo [0:GD];
  geo_t geo_in;

  logic signed [CW-1:0] sx, sy, ex, ey, cxi, cyi;
  logic signed [DW-1:0] ddx, ddy, hx, hy, sumx, sumy;

  // output side
  result_t fin, skid_word;
  logic skid_valid;

  assign adv = !skid_valid;
  assign item_ready = adv;

  // angle reduction for the three axes
  rrb_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_a (
    .angle(item.angle_about_x), .lane(pa));
  rrb_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_b (
    .angle(item.angle_about_y), .lane(pb));
  rrb_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_c (
    .angle(item.angle_about_z), .lane(pc));

  // centre and corner offsets
  always_comb begin
    sx = item.start_x[CW-1:0];
    sy = item.start_y[CW-1:0];
    ex = item.end_x[CW-1:0];
    ey = item.end_y[CW-1:0];
    ddx = {ex[CW-1], ex} - {sx[CW-1], sx};
    ddy = {ey[CW-1], ey} - {sy[CW-1], sy};
    hx = $signed(ddx + {{(DW-1){1'b0}}, ddx[DW-1]}) >>> 1;
    hy = $signed(ddy + {{(DW-1){1'b0}}, ddy[DW-1]}) >>> 1;
    sumx = {sx[CW-1], sx} + hx;
    sumy = {sy[CW-1], sy} + hy;
    cxi = sumx[CW-1:0];
    cyi = sumy[CW-1:0];
    geo_in.cx = cxi;
    geo_in.cy = cyi;
    geo_in.dax = {sx[CW-1], sx} - {cxi[CW-1], cxi};
    geo_in.day = {sy[CW-1], sy} - {cyi[CW-1], cyi};
    geo_in.dbx = {ex[CW-1], ex} - {cxi[CW-1], cxi};
    geo_in.dby = {ey[CW-1], ey} - {cyi[CW-1], cyi};
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], item_valid};
    end
  end

  // entry registers and geometry delay line
  always_ff @(posedge clk) begin
    if (adv) begin
      la[0] <= pa;
      lb[0] <= pb;
      lc[0] <= pc;
      geo[0] <= geo_in;
      for (int k = 1; k <= GD; k++) geo[k] <= geo[k-1];
    end
  end

  // cordic cell rows, one per angle
  for (genvar i = 0; i < N; i++) begin : g_cell
    rrb_cordic_cell #(.STAGE(i)) u_ca (.clk(clk), .en(adv), .d(la[i]), .q(la[i+1]));
    rrb_cordic_cell #(.STAGE(i)) u_cb (.clk(clk), .en(adv), .d(lb[i]), .q(lb[i+1]));
    rrb_cordic_cell #(.STAGE(i)) u_cc (.clk(clk), .en(adv), .d(lc[i]), .q(lc[i+1]));
  end

  // sine and cosine stage
  logic signed [SC_W-1:0] sa, ca, sb, cb, sc, cc;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa <= sc_fix(la[N].y, la[N].neg);
      ca <= sc_fix(la[N].x, la[N].neg);
      sb <= sc_fix(lb[N].y, lb[N].neg);
      cb <= sc_fix(lb[N].x, lb[N].neg);
      sc <= sc_fix(lc[N].y, lc[N].neg);
      cc <= sc_fix(lc[N].x, lc[N].neg);
    end
  end

  // first products
  logic signed [2*SC_W-1:0] pbc, pbs;
  logic signed [2*SC_W:0] nbs;
  logic signed [2*SC_W-1:0] casc1, cacc1, sasb1;
  logic signed [SC_W-1:0] sc1, cc1;
  logic signed [MW-1:0] m00_1, m01_1;
  always_comb begin
    pbc = cb * cc;
    pbs = cb * sc;
    nbs = -pbs;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m00_1 <= MW'(pbc >>> 16);
      m01_1 <= MW'(nbs >>> 16);
      casc1 <= ca * sc;
      cacc1 <= ca * cc;
      sasb1 <= sa * sb;
      sc1 <= sc;
      cc1 <= cc;
    end
  end

  // second products
  logic signed [3*SC_W-1:0] p2, q2;
  logic signed [2*SC_W-1:0] casc2, cacc2;
  logic signed [MW-1:0] m00_2, m01_2;
  always_ff @(posedge clk) begin
    if (adv) begin
      p2 <= sasb1 * cc1;
      q2 <= sasb1 * sc1;
      casc2 <= casc1;
      cacc2 <= cacc1;
      m00_2 <= m00_1;
      m01_2 <= m01_1;
    end
  end

  // lower matrix row
  logic signed [SW-1:0] s10, s11;
  logic signed [MW-1:0] m00_3, m01_3, m10_3, m11_3;
  always_comb begin
    s10 = (SW'(casc2) <<< 16) + SW'(p2);
    s11 = (SW'(cacc2) <<< 16) - SW'(q2);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m00_3 <= m00_2;
      m01_3 <= m01_2;
      m10_3 <= MW'(s10 >>> 32);
      m11_3 <= MW'(s11 >>> 32);
    end
  end

  // corner products
  logic signed [PW-1:0] pa0, pa1, qa0, qa1, pb0, pb1, qb0, qb1;
  logic signed [CW-1:0] cx4, cy4;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa0 <= m00_3 * geo[GD].dax;
      pa1 <= m01_3 * geo[GD].day;
      qa0 <= m10_3 * geo[GD].dax;
      qa1 <= m11_3 * geo[GD].day;
      pb0 <= m00_3 * geo[GD].dbx;
      pb1 <= m01_3 * geo[GD].dby;
      qb0 <= m10_3 * geo[GD].dbx;
      qb1 <= m11_3 * geo[GD].dby;
      cx4 <= geo[GD].cx;
      cy4 <= geo[GD].cy;
    end
  end

  // rotated corners
  logic signed [31:0] rax, ray, rbx, rby;
  always_ff @(posedge clk) begin
    if (adv) begin
      rax <= rot(cx4, pa0, pa1);
      ray <= rot(cy4, qa0, qa1);
      rbx <= rot(cx4, pb0, pb1);
      rby <= rot(cy4, qb0, qb1);
    end
  end

  // order into minimum and maximum
  always_comb begin
    fin.min_x = (rax > rbx) ? rbx : rax;
    fin.max_x = (rax > rbx) ? rax : rbx;
    fin.min_y = (ray > rby) ? rby : ray;
    fin.max_y = (ray > rby) ? ray : rby;
  end

  // output word and skid word control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result_ready) skid_valid <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (vld[LAST]) skid_valid <= 1'b1;
    end else begin
      result_valid <= vld[LAST];
    end
  end

  // output word and skid word data
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_ready) result <= skid_word;
    end else if (result_valid && !result_ready) begin
      skid_word <= fin;
    end else begin
      result <= fin;
    end
  end

  `RRB_ASSERT_IMPLY(a_skid_needs_main, skid_valid, result_valid, "skid word without output word")
  `RRB_ASSERT_IMPLY(a_skid_on_stall, $rose(skid_valid), $past(result_valid && !result_ready), "skid filled without a stall")
  `RRB_ASSERT_IMPLY(a_ordered, result_valid, (result.min_x <= result.max_x) && (result.min_y <= result.max_y), "bounds out of order")
  `RRB_ASSERT_NEXT(a_pipe_holds, skid_valid && !result_ready, $stable(vld), "pipeline moved while stalled")

endmodule
